// ===== design/mtep_pkg.sv =====
package mtep_pkg;

    // parse phase codes
    localparam logic [3:0] PH_DELTA      = 4'd0;
    localparam logic [3:0] PH_STATUS     = 4'd1;
    localparam logic [3:0] PH_NOTE_KEY   = 4'd2;
    localparam logic [3:0] PH_NOTE_VEL   = 4'd3;
    localparam logic [3:0] PH_META_TYPE  = 4'd4;
    localparam logic [3:0] PH_META_LEN   = 4'd5;
    localparam logic [3:0] PH_TEMPO_LEN  = 4'd6;
    localparam logic [3:0] PH_TEMPO_DATA = 4'd7;
    localparam logic [3:0] PH_SKIP       = 4'd8;

    // result kinds
    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_TEMPO    = 2'd2;

    // byte values the parser looks for
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_PROGRAM  = 8'hC0;
    localparam logic [7:0] STATUS_PRESSURE = 8'hD0;
    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] META_TEMPO      = 8'h51;
    localparam logic [7:0] TEMPO_LEN       = 8'd3;

    localparam logic [15:0] LIMIT_RESET = 16'd500;

    // register byte address of event_limit
    localparam logic [2:0] ADDR_EVENT_LIMIT = 3'd0;

    // result queue depth
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  note;
        logic [7:0]  vel;
        logic [31:0] time_abs;
        logic [23:0] tempo;
        logic [15:0] index;
        logic        last;
    } t_result;

    // results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ===== design/mtep_parser.sv =====
module mtep_parser import mtep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_limit,
    output t_push       o_push
);

    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_delta, n_delta;
    logic [31:0] r_abs, n_abs;
    logic [7:0]  r_note, n_note;
    logic [23:0] r_tempo, n_tempo;
    logic [7:0]  r_skip, n_skip;
    logic [15:0] r_count, n_count;

    logic        ok0, ok1;
    logic [31:0] vlq;
    logic [23:0] tempo_shift;
    logic [7:0]  skip_dec;
    logic [7:0]  hi;
    logic [16:0] count_inc;

    // room left under the limit for one or two results
    assign count_inc   = {1'b0, r_count} + 17'd1;
    assign ok0         = (r_count < i_limit);
    assign ok1         = (count_inc < {1'b0, i_limit});
    assign vlq         = {r_delta[24:0], i_byte[6:0]};
    assign tempo_shift = {r_tempo[15:0], i_byte};
    assign skip_dec    = r_skip - 8'd1;
    assign hi          = i_byte & 8'hF0;

    // per-byte parse step
    always_comb begin
        n_phase = r_phase;
        n_delta = r_delta;
        n_abs   = r_abs;
        n_note  = r_note;
        n_tempo = r_tempo;
        n_skip  = r_skip;
        n_count = r_count;

        o_push.count          = 2'd0;
        o_push.res0.kind      = KIND_NOTE_ON;
        o_push.res0.note      = r_note;
        o_push.res0.vel       = i_byte;
        o_push.res0.time_abs  = r_abs;
        o_push.res0.tempo     = '0;
        o_push.res0.index     = r_count;
        o_push.res0.last      = !ok1;
        o_push.res1.kind      = KIND_NOTE_OFF;
        o_push.res1.note      = r_note;
        o_push.res1.vel       = i_byte;
        o_push.res1.time_abs  = r_abs;
        o_push.res1.tempo     = '0;
        o_push.res1.index     = count_inc[15:0];
        o_push.res1.last      = 1'b1;

        unique case (r_phase)
            PH_STATUS: begin
                priority if (!i_byte[7]) begin
                    n_phase = PH_DELTA;
                end else if (hi == STATUS_NOTE_ON) begin
                    n_phase = PH_NOTE_KEY;
                end else if (i_byte == STATUS_META) begin
                    n_phase = PH_META_TYPE;
                end else if (hi == STATUS_PROGRAM || hi == STATUS_PRESSURE) begin
                    n_skip  = 8'd1;
                    n_phase = PH_SKIP;
                end else begin
                    n_skip  = 8'd2;
                    n_phase = PH_SKIP;
                end
            end
            PH_NOTE_KEY: begin
                n_note  = i_byte;
                n_phase = PH_NOTE_VEL;
            end
            PH_NOTE_VEL: begin
                o_push.count = {ok0 & ok1, ok0 & !ok1};
                n_count      = r_count + {14'd0, ok0 & ok1, ok0 & !ok1};
                n_phase      = PH_DELTA;
            end
            PH_META_TYPE: begin
                n_phase = (i_byte == META_TEMPO) ? PH_TEMPO_LEN : PH_META_LEN;
            end
            PH_TEMPO_LEN: begin
                n_skip = i_byte;
                if (i_byte == TEMPO_LEN) begin
                    n_tempo = '0;
                    n_phase = PH_TEMPO_DATA;
                end else begin
                    n_phase = (i_byte == 8'd0) ? PH_DELTA : PH_SKIP;
                end
            end
            PH_META_LEN: begin
                n_skip  = i_byte;
                n_phase = (i_byte == 8'd0) ? PH_DELTA : PH_SKIP;
            end
            PH_TEMPO_DATA: begin
                n_tempo = tempo_shift;
                n_skip  = skip_dec;
                if (skip_dec == 8'd0) begin
                    o_push.res0.kind  = KIND_TEMPO;
                    o_push.res0.note  = '0;
                    o_push.res0.vel   = '0;
                    o_push.res0.tempo = tempo_shift;
                    o_push.res0.last  = 1'b1;
                    o_push.count      = {1'b0, ok0};
                    n_count           = r_count + {15'd0, ok0};
                    n_phase           = PH_DELTA;
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 8'd0) begin
                    n_phase = PH_DELTA;
                end
            end
            default: begin
                // delta time, and any unused phase code
                if (i_byte[7]) begin
                    n_delta = vlq;
                    n_phase = PH_DELTA;
                end else begin
                    n_abs   = r_abs + vlq;
                    n_delta = '0;
                    n_phase = PH_STATUS;
                end
            end
        endcase

        // end of data returns the parser to its start
        if (i_last) begin
            n_phase = PH_DELTA;
            n_delta = '0;
            n_abs   = '0;
            n_note  = '0;
            n_tempo = '0;
            n_skip  = '0;
            n_count = '0;
        end

        if (!i_accept) begin
            o_push.count = 2'd0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA;
            r_delta <= '0;
            r_abs   <= '0;
            r_note  <= '0;
            r_tempo <= '0;
            r_skip  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_delta <= n_delta;
            r_abs   <= n_abs;
            r_note  <= n_note;
            r_tempo <= n_tempo;
            r_skip  <= n_skip;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/mtep_res_queue.sv =====
module mtep_res_queue import mtep_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, n_wr;
    logic [QUEUE_AW-1:0]   r_rd, n_rd;
    logic [QUEUE_AW:0]     r_fill, n_fill;
    logic [QUEUE_AW-1:0]   wr_next;
    logic                  pop_ok;

    assign wr_next = r_wr + 1'b1;
    assign o_valid = (r_fill != '0);
    assign o_head  = r_mem[r_rd];
    assign pop_ok  = i_pop && o_valid;
    // room for the two results a byte can cause
    assign o_room  = (r_fill <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

    // pointer and fill update
    always_comb begin
        n_wr   = r_wr + i_push.count[QUEUE_AW-1:0];
        n_rd   = r_rd + {{(QUEUE_AW-1){1'b0}}, pop_ok};
        n_fill = r_fill + {{(QUEUE_AW-1){1'b0}}, i_push.count}
                 - {{QUEUE_AW{1'b0}}, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

endmodule

// ===== design/midi_track_event_parser_top.sv =====
// the results of an accepted byte are registered in the result queue and offered on the master side from its head
// throughput: one byte per cycle while o_s_tready is high; a note-on velocity byte
//   puts two results out, which leave singly; the four-entry result queue absorbs the difference
// o_s_tready drops while the queue holds more than two results
// reset (synchronous, active low) clears the parser, the time, the event count and
//   the queue, and sets event_limit to 500
module midi_track_event_parser_top import mtep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tlast,   // end_of_data
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // note_number, velocity, event_time, tempo_value, event_index
    output logic [1:0]  o_m_tuser,   // event_kind
    output logic        o_m_tlast,   // last_of_run
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_limit;
    logic        in_accept;
    logic        room;
    t_push       push;
    t_result     head;

    assign pready     = 1'b1;
    assign o_s_tready = room;
    assign in_accept  = i_s_tvalid && room;

    // register write and read back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == ADDR_EVENT_LIMIT[2]) begin
            r_limit <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_EVENT_LIMIT[2]) ? {16'd0, r_limit} : 32'd0;

    mtep_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_limit  (r_limit),
        .o_push   (push)
    );

    mtep_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_tready),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .o_head  (head)
    );

    // result packing
    assign o_m_tdata = {head.index, head.tempo, head.time_abs, head.vel, head.note};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

endmodule

// ===== tb/sv/midi_event_checker.sv =====
module midi_event_checker import mtep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tlast,   // end_of_data
    // result stream
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [87:0] i_m_tdata,   // note_number, velocity, event_time, tempo_value, event_index
    input  logic [1:0]  i_m_tuser,   // event_kind
    input  logic        i_m_tlast,   // last_of_run
    // configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [7:0] DATA_MAX = 8'h7F;

    // predicted parser state
    logic [15:0] limit_q;
    logic [3:0]  phase;
    logic [31:0] delta_acc;
    logic [31:0] abs_time;
    logic [7:0]  key_hold;
    logic [23:0] tempo_acc;
    logic [7:0]  skip_left;
    logic [15:0] pred_count;

    t_result expected_events[$];
    int      fail_cnt = 0;

    task automatic log_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic void clear_parse();
        phase      = PH_DELTA;
        delta_acc  = '0;
        abs_time   = '0;
        key_hold   = '0;
        tempo_acc  = '0;
        skip_left  = '0;
        pred_count = '0;
    endfunction

    // queue one predicted event unless the limit holds it back
    function automatic void push_event(input logic [1:0] kind, input logic [7:0] note,
                                       input logic [7:0] vel, input logic [23:0] tempo);
        t_result r;
        if (pred_count >= limit_q) begin
            return;
        end
        r.kind     = kind;
        r.note     = note;
        r.vel      = vel;
        r.time_abs = abs_time;
        r.tempo    = tempo;
        r.index    = pred_count;
        r.last     = 1'b0;
        expected_events.push_back(r);
        pred_count++;
    endfunction

    function automatic void begin_skip(input logic [7:0] n);
        skip_left = n;
        phase     = (n == 8'd0) ? PH_DELTA : PH_SKIP;
    endfunction

    // advance the parser by one accepted byte
    function automatic void parse_byte(input logic [7:0] b, input logic eod);
        int queued;
        queued = expected_events.size();
        case (phase)
            PH_STATUS: begin
                if (b <= DATA_MAX) begin
                    phase = PH_DELTA;
                end else if (b[7:4] == STATUS_NOTE_ON[7:4]) begin
                    phase = PH_NOTE_KEY;
                end else if (b == STATUS_META) begin
                    phase = PH_META_TYPE;
                end else if (b[7:4] == STATUS_PROGRAM[7:4] ||
                             b[7:4] == STATUS_PRESSURE[7:4]) begin
                    begin_skip(8'd1);
                end else begin
                    begin_skip(8'd2);
                end
            end
            PH_NOTE_KEY: begin
                key_hold = b;
                phase    = PH_NOTE_VEL;
            end
            PH_NOTE_VEL: begin
                push_event(KIND_NOTE_ON, key_hold, b, 24'd0);
                push_event(KIND_NOTE_OFF, key_hold, b, 24'd0);
                phase = PH_DELTA;
            end
            PH_META_TYPE: begin
                phase = (b == META_TEMPO) ? PH_TEMPO_LEN : PH_META_LEN;
            end
            PH_TEMPO_LEN: begin
                if (b == TEMPO_LEN) begin
                    tempo_acc = '0;
                    skip_left = TEMPO_LEN;
                    phase     = PH_TEMPO_DATA;
                end else begin
                    begin_skip(b);
                end
            end
            PH_META_LEN: begin
                begin_skip(b);
            end
            PH_TEMPO_DATA: begin
                tempo_acc = {tempo_acc[15:0], b};
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'd0) begin
                    push_event(KIND_TEMPO, 8'd0, 8'd0, tempo_acc);
                    phase = PH_DELTA;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'd0) begin
                    phase = PH_DELTA;
                end
            end
            default: begin
                // variable-length delta, seven bits per byte
                delta_acc = {delta_acc[24:0], b[6:0]};
                if (b[7]) begin
                    phase = PH_DELTA;
                end else begin
                    abs_time  = abs_time + delta_acc;
                    delta_acc = '0;
                    phase     = PH_STATUS;
                end
            end
        endcase
        if (expected_events.size() > queued) begin
            expected_events[expected_events.size() - 1].last = 1'b1;
        end
        if (eod) begin
            clear_parse();
        end
    endfunction

    // compare one result transaction with the oldest prediction
    task automatic check_event();
        t_result want;
        t_result got;
        got.kind     = i_m_tuser;
        got.note     = i_m_tdata[7:0];
        got.vel      = i_m_tdata[15:8];
        got.time_abs = i_m_tdata[47:16];
        got.tempo    = i_m_tdata[71:48];
        got.index    = i_m_tdata[87:72];
        got.last     = i_m_tlast;
        if (expected_events.size() == 0) begin
            log_failure($sformatf("unexpected result kind=%0d note=%02h idx=%0d",
                                  got.kind, got.note, got.index));
            return;
        end
        want = expected_events.pop_front();
        if (want.kind != got.kind || want.note != got.note || want.vel != got.vel ||
            want.time_abs != got.time_abs || want.tempo != got.tempo ||
            want.index != got.index || want.last != got.last) begin
            log_failure($sformatf(
                "result mismatch exp k=%0d n=%02h v=%02h t=%0d tp=%0d i=%0d l=%0d %s",
                want.kind, want.note, want.vel, want.time_abs, want.tempo, want.index,
                want.last,
                $sformatf("got k=%0d n=%02h v=%02h t=%0d tp=%0d i=%0d l=%0d",
                          got.kind, got.note, got.vel, got.time_abs, got.tempo,
                          got.index, got.last)));
        end
    endtask

    // watch all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_q = LIMIT_RESET;
            clear_parse();
            expected_events.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_EVENT_LIMIT) begin
                if (i_pwrite) begin
                    limit_q = i_pwdata[15:0];
                end else if (i_prdata != {16'd0, limit_q}) begin
                    log_failure($sformatf("event_limit read exp %0d got %0d",
                                          limit_q, i_prdata));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                parse_byte(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_event();
            end
        end
        o_pending    = expected_events.size();
        o_fail_count = fail_cnt;
    end

endmodule

// ===== tb/sv/tb_midi_track_event_parser_top.sv =====
module tb_midi_track_event_parser_top import mtep_pkg::*;;

    localparam int QUIET_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // data_byte
    logic        i_s_tlast = 1'b0; // end_of_data
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [87:0] o_m_tdata;        // note_number, velocity, event_time, tempo_value, event_index
    logic [1:0]  o_m_tuser;        // event_kind
    logic        o_m_tlast;        // last_of_run
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_idle = 6;
    int recv_idle = 67;
    int bytes_sent = 0;
    int fail_count;
    int pending;
    int quiet_cycles = 0;

    // opening bytes: note extremes, two-byte delta, max tempo, program change,
    // data byte in status place, zero-length meta closed by end of data
    logic [7:0] opening_bytes [25] = '{
        8'h00, 8'h90, 8'hFF, 8'h00,
        8'h81, 8'h00, 8'h9F, 8'h00, 8'h7F,
        8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'hC5, 8'h12,
        8'h00, 8'h20,
        8'h00, 8'hFF, 8'h01, 8'h00
    };

    always #5 i_clk = ~i_clk;

    midi_track_event_parser_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    midi_event_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stalls at random
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eod);
        while ($urandom_range(0, 99) < send_idle) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        i_s_tlast  = eod;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // header byte then n random bytes, end of data on the final one
    task automatic send_tail(input logic [7:0] hdr, input int n, input logic eod);
        send_byte(hdr, eod && n == 0);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(0, 255)), eod && i == n - 1);
        end
    endtask

    task automatic send_delta(input int nbytes);
        for (int i = 0; i < nbytes - 1; i++) begin
            send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
        end
        send_byte(8'($urandom_range(0, 127)), 1'b0);
    endtask

    // one well-formed event with random content, or a noise byte
    task automatic send_random_event();
        logic       eod;
        int         pick;
        int         len;
        logic [7:0] mtype;
        eod  = ($urandom_range(0, 99) < 4);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            send_delta(1);
        end else if (pick < 92) begin
            send_delta($urandom_range(2, 3));
        end else begin
            send_delta($urandom_range(4, 6));
        end
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_byte(STATUS_NOTE_ON | 8'($urandom_range(0, 15)), 1'b0);
            send_tail(8'($urandom_range(0, 255)), 1, eod);
        end else if (pick < 50) begin
            send_byte(STATUS_META, 1'b0);
            send_byte(META_TEMPO, 1'b0);
            send_tail(TEMPO_LEN, 3, eod);
        end else if (pick < 55) begin
            // tempo with a wrong length is skipped
            len = $urandom_range(0, 6);
            if (len >= 3) begin
                len++;
            end
            send_byte(STATUS_META, 1'b0);
            send_byte(META_TEMPO, 1'b0);
            send_tail(8'(len), len, eod);
        end else if (pick < 65) begin
            mtype = 8'($urandom_range(0, 255));
            if (mtype == META_TEMPO) begin
                mtype = 8'h2F;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
            send_byte(STATUS_META, 1'b0);
            send_byte(mtype, 1'b0);
            send_tail(8'(len), len, eod);
        end else if (pick < 75) begin
            case ($urandom_range(0, 3))
                0: mtype = 8'h80;
                1: mtype = 8'hA0;
                2: mtype = 8'hB0;
                default: mtype = 8'hE0;
            endcase
            send_tail(mtype | 8'($urandom_range(0, 15)), 2, eod);
        end else if (pick < 83) begin
            mtype = $urandom_range(0, 1) ? STATUS_PROGRAM : STATUS_PRESSURE;
            send_tail(mtype | 8'($urandom_range(0, 15)), 1, eod);
        end else if (pick < 90) begin
            send_tail(8'($urandom_range(8'hF0, 8'hFE)), 2, eod);
        end else begin
            send_tail(8'($urandom_range(0, 127)), 0, eod);
        end
    endtask

    // hold the sender until every predicted result has arrived
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] limit, input int s_idle, input int r_idle,
                             input int n_items);
        int target;
        wait_drained();
        apb_access(1'b1, ADDR_EVENT_LIMIT, {16'd0, limit});
        apb_access(1'b0, ADDR_EVENT_LIMIT, 32'd0);
        send_idle = s_idle;
        recv_idle = r_idle;
        target    = bytes_sent + n_items;
        while (bytes_sent < target) begin
            send_random_event();
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        apb_access(1'b0, ADDR_EVENT_LIMIT, 32'd0);

        // directed opening at the reset limit
        for (int i = 0; i < 25; i++) begin
            send_byte(opening_bytes[i], i == 24);
        end

        run_phase(16'hFFFF, 6, 67, 90);

        // build up the count, then lower the limit beneath it
        wait_drained();
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 3; i++) begin
            send_byte(8'h00, 1'b0);
            send_byte(STATUS_NOTE_ON | 8'(i), 1'b0);
            send_tail(8'($urandom_range(0, 255)), 1, 1'b0);
        end
        run_phase(16'd2, 6, 67, 70);

        run_phase(16'd0, 67, 6, 50);
        run_phase(16'd3, 67, 6, 90);
        run_phase(16'($urandom_range(1, 20)), 0, 0, 100);

        wait_drained();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== midi_track_event_parser_top.f =====
design/mtep_pkg.sv
design/mtep_parser.sv
design/mtep_res_queue.sv
design/midi_track_event_parser_top.sv
tb/sv/midi_event_checker.sv
tb/sv/tb_midi_track_event_parser_top.sv
